/* hw/rtl/mqpd_pkg.sv */
// Package for the multi-queue priority deque: field widths, command and
// status codes, controller state type and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package mqpd_pkg;

  localparam int NUM_QUEUES_DEF  = 128;
  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int IDX_W   = 7;
  localparam int ID_W    = 16;
  localparam int ENTRY_W = ID_W + 1;   // {urgent, id}
  localparam int CFG_W   = 8;
  localparam int STAT_W  = 3;

  localparam logic [CFG_W-1:0] ACTIVE_QUEUES_RST = 8'd20;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_ADDED  = 3'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL   = 3'd1;
  localparam logic [STAT_W-1:0] STATUS_TAKEN  = 3'd2;
  localparam logic [STAT_W-1:0] STATUS_EMPTY  = 3'd3;
  localparam logic [STAT_W-1:0] STATUS_BADIDX = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_META,
    S_ENTRY
  } state_t;

endpackage

/* hw/rtl/multi_queue_priority_deque.sv */
// Top level of the multi-queue priority deque: command sequencer around a
// per-queue metadata RAM and an entry RAM. Uses mqpd_pkg and mqpd_ram.
`timescale 1ns / 1ps

// Keeps NUM_QUEUES bounded queues of QUEUE_DEPTH items each. A command is
// taken when start is high and busy is low. Add puts the item at the tail,
// or at the head when urgent; take pops the head. Each command gives exactly
// one result, shown for one cycle with done high; the receiver cannot stall
// it, so sample it on that cycle. An add, a refused command and a take on
// an empty queue give their result from the metadata RAM read; a successful
// take reads the metadata RAM, then the entry RAM. busy is high from the
// accept until done, so a new command may be accepted in the cycle done is
// shown. After reset a clearing pass zeroes the metadata RAM, one queue per
// cycle, with busy high. The active_queues register (reset 20) is written
// over the cfg channel, which is always ready; write it only while no
// command is in flight. Indices at or above active_queues or NUM_QUEUES
// give status bad index and change nothing.
module multi_queue_priority_deque
  import mqpd_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [IDX_W-1:0]                     queue_index,
  input  logic [ID_W-1:0]                      item_id,
  input  logic                                 urgent,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_W-1:0]                     cfg_data,
  // result
  output logic                                 done,
  output logic [STAT_W-1:0]                    status,
  output logic [ID_W-1:0]                      out_item_id,
  output logic                                 out_urgent,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     queue_length
);

  localparam int QAW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int HW     = $clog2(QUEUE_DEPTH);
  localparam int MW     = CW + HW;               // {count, head}
  localparam int EDEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int EAW    = $clog2(EDEPTH);

  // control state
  state_t            state, state_next;
  logic [QAW-1:0]    clr_addr;
  logic [CFG_W-1:0]  active_queues;

  // latched command
  logic              cmd_r;
  logic [IDX_W-1:0]  qidx_r;
  logic [ID_W-1:0]   id_r;
  logic              urg_r;
  logic [CW-1:0]     len_r;

  // RAM ports
  logic              meta_we, meta_re;
  logic [QAW-1:0]    meta_waddr, meta_raddr;
  logic [MW-1:0]     meta_wdata, meta_rdata;
  logic              entry_we, entry_re;
  logic [EAW-1:0]    entry_addr;
  logic [ENTRY_W-1:0] entry_rdata;

  // decode of the metadata word
  logic [CW-1:0]     meta_cnt;
  logic [HW-1:0]     meta_head, head_dec, head_inc, tail, slot;
  logic [HW:0]       tail_sum;
  logic [31:0]       q_ext, in_q_ext;
  logic [QAW-1:0]    q_addr;
  logic [EAW-1:0]    entry_base;
  logic              bad, full, empty;

  // result staging
  logic              res_load;
  logic [STAT_W-1:0] res_status;
  logic [ID_W-1:0]   res_id;
  logic              res_urg;
  logic [CW-1:0]     res_len;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign meta_cnt  = meta_rdata[MW-1:HW];
  assign meta_head = meta_rdata[HW-1:0];

  assign q_ext    = 32'(qidx_r);
  assign in_q_ext = 32'(queue_index);
  assign q_addr   = q_ext[QAW-1:0];

  assign bad   = (CFG_W'(qidx_r) >= active_queues) || (q_ext >= 32'(NUM_QUEUES));
  assign full  = (meta_cnt >= CW'(QUEUE_DEPTH));
  assign empty = (meta_cnt == '0);

  // ring arithmetic, modulo QUEUE_DEPTH
  assign head_dec = (meta_head == '0) ? HW'(QUEUE_DEPTH - 1) : meta_head - 1'b1;
  assign head_inc = (meta_head == HW'(QUEUE_DEPTH - 1)) ? '0 : meta_head + 1'b1;
  assign tail_sum = {1'b0, meta_head} + (HW+1)'(meta_cnt);
  assign tail     = (tail_sum >= (HW+1)'(QUEUE_DEPTH))
                    ? HW'(tail_sum - (HW+1)'(QUEUE_DEPTH)) : tail_sum[HW-1:0];

  // take reads the head; urgent add writes before it; normal add at tail
  assign slot = (cmd_r == CMD_TAKE) ? meta_head : (urg_r ? head_dec : tail);

  assign entry_base = EAW'(q_ext * 32'(QUEUE_DEPTH));
  assign entry_addr = entry_base + EAW'(slot);

  mqpd_ram #(.WIDTH(MW), .DEPTH(NUM_QUEUES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  mqpd_ram #(.WIDTH(ENTRY_W), .DEPTH(EDEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_addr),
    .wdata ({urg_r, id_r}),
    .re    (entry_re),
    .raddr (entry_addr),
    .rdata (entry_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == QAW'(NUM_QUEUES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_META;
      end
      S_META: begin
        if (!bad && cmd_r == CMD_TAKE && !empty) state_next = S_ENTRY;
        else state_next = S_IDLE;
      end
      S_ENTRY: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // memory controls and result values
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = q_addr;
    meta_wdata = '0;
    meta_re    = 1'b0;
    meta_raddr = in_q_ext[QAW-1:0];
    entry_we   = 1'b0;
    entry_re   = 1'b0;
    res_load   = 1'b0;
    res_status = STATUS_BADIDX;
    res_id     = '0;
    res_urg    = 1'b0;
    res_len    = '0;
    case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_addr;
      end
      S_IDLE: begin
        meta_re = start;
      end
      S_META: begin
        if (bad) begin
          res_load = 1'b1;
        end else if (cmd_r == CMD_ADD) begin
          res_load = 1'b1;
          if (full) begin
            res_status = STATUS_FULL;
            res_len    = meta_cnt;
          end else begin
            entry_we   = 1'b1;
            meta_we    = 1'b1;
            meta_wdata = {meta_cnt + 1'b1, urg_r ? head_dec : meta_head};
            res_status = STATUS_ADDED;
            res_len    = meta_cnt + 1'b1;
          end
        end else if (empty) begin
          res_load   = 1'b1;
          res_status = STATUS_EMPTY;
        end else begin
          entry_re   = 1'b1;
          meta_we    = 1'b1;
          meta_wdata = {meta_cnt - 1'b1, head_inc};
        end
      end
      S_ENTRY: begin
        res_load   = 1'b1;
        res_status = STATUS_TAKEN;
        res_id     = entry_rdata[ID_W-1:0];
        res_urg    = entry_rdata[ID_W];
        res_len    = len_r;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      active_queues <= ACTIVE_QUEUES_RST;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_load;
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (cfg_valid && cfg_ready) active_queues <= cfg_data;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_r  <= command;
      qidx_r <= queue_index;
      id_r   <= item_id;
      urg_r  <= urgent;
    end
    if (state == S_META) len_r <= meta_cnt - 1'b1;
    if (res_load) begin
      status       <= res_status;
      out_item_id  <= res_id;
      out_urgent   <= res_urg;
      queue_length <= res_len;
    end
  end

endmodule

/* hw/rtl/mqpd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module mqpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
